// ===== hdl/nlss_pkg.sv =====
// Shared types and constants for the nearest lane sweep selector.
package nlss_pkg;

    // Fixed field widths of the transaction payload.
    localparam int unsigned FIELD_COORD_W = 24;
    localparam int unsigned LINK_W        = 8;
    localparam int unsigned THR_W         = 23;
    localparam logic [THR_W-1:0] THR_RESET = 23'd128;

    // Function codes carried in the func field.
    localparam logic [1:0] FUNC_LANE_WRITE = 2'd0;
    localparam logic [1:0] FUNC_POSE       = 2'd1;
    localparam logic [1:0] FUNC_SET_ENABLE = 2'd2;

    // One lane table entry without its start point.
    typedef struct packed {
        logic              present;
        logic              has_point;
        logic              sweep;
        logic              back_valid;
        logic [LINK_W-1:0] back;
        logic              fwd_valid;
        logic [LINK_W-1:0] fwd;
    } lane_flags_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_THR,
        ST_RD,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_EVAL,
        ST_NEXT,
        ST_FINAL,
        ST_RESULT
    } state_t;

    // Which search a candidate belongs to.
    typedef enum logic [1:0] {
        PH_CACHE,
        PH_NEAR,
        PH_GLOBAL
    } phase_t;

    // Position within the nearby search.
    typedef enum logic [1:0] {
        NS_SELF,
        NS_BACK,
        NS_FWD
    } near_step_t;

endpackage

// ===== hdl/nearest_lane_sweep_selector_core.sv =====
// Lane table with nearest-lane search that reports sweep status changes.
//
// The input channel (s_valid/s_ready) carries three kinds of transaction:
// a lane table write, a pose update and an enable setting. The result
// channel (m_valid/m_ready) carries the new sweep status, and only when the
// status changes. The search threshold is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. One squaring multiplier is shared
// for the threshold and for every distance; each lane that takes part goes
// through read, difference, square x, square y, sum, compare and advance,
// and an ineligible lane through read, difference and advance.
// The block accepts one transaction at a time; s_ready is high only when
// the sequencer is idle.
// After reset the lane flag memory is cleared, one entry a cycle, with
// s_ready low.
// A result waits in an output register; the block accepts new transactions
// while it waits, and a later result holds the sequencer until the
// receiver has taken the earlier one.
module nearest_lane_sweep_selector_core #(
    parameter int unsigned LANE_ENTRIES = 256,
    parameter int unsigned COORD_BITS   = 24
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic [nlss_pkg::THR_W-1:0]                  cfg_wr_data,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [1:0]                                  s_func,
    input  logic [7:0]                                  s_lane_index,
    input  logic signed [nlss_pkg::FIELD_COORD_W-1:0]   s_pos_x,
    input  logic signed [nlss_pkg::FIELD_COORD_W-1:0]   s_pos_y,
    input  logic                                        s_lane_present,
    input  logic                                        s_lane_has_point,
    input  logic                                        s_lane_sweep,
    input  logic                                        s_back_link_valid,
    input  logic [nlss_pkg::LINK_W-1:0]                 s_back_link,
    input  logic                                        s_fwd_link_valid,
    input  logic [nlss_pkg::LINK_W-1:0]                 s_fwd_link,
    input  logic                                        s_enable_value,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic                                        m_sweep_on
);

    localparam int unsigned AW     = (LANE_ENTRIES > 1) ? $clog2(LANE_ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(LANE_ENTRIES + 1);
    localparam int unsigned CB     = COORD_BITS;
    localparam int unsigned MW     = (CB > nlss_pkg::THR_W) ? CB : nlss_pkg::THR_W;
    localparam int unsigned PW     = 2 * MW;
    localparam int unsigned DW     = PW + 1;
    localparam logic [AW-1:0] LAST = AW'(LANE_ENTRIES - 1);

    // Memories: lane flags (cleared after reset) and lane start points.
    nlss_pkg::lane_flags_t flags_mem [LANE_ENTRIES];
    logic [2*CB-1:0]       pos_mem   [LANE_ENTRIES];
    nlss_pkg::lane_flags_t flags_q_reg;
    logic [2*CB-1:0]       pos_q_reg;

    nlss_pkg::state_t     state_reg, state_next;
    nlss_pkg::phase_t     phase_reg, phase_next;
    nlss_pkg::near_step_t step_reg, step_next;
    logic [AW-1:0]        cand_reg, cand_next;

    // Captured transaction.
    logic [1:0]            func_reg;
    logic [7:0]            idx_reg;
    logic [CB-1:0]         pose_x_reg, pose_y_reg;
    nlss_pkg::lane_flags_t new_flags_reg;
    logic                  en_val_reg;

    logic                  enabled_reg, enabled_next;
    logic                  status_reg, status_next;
    logic                  cache_valid_reg, cache_valid_next;
    logic [CB-1:0]         cached_x_reg, cached_x_next;
    logic [CB-1:0]         cached_y_reg, cached_y_next;
    logic [AW-1:0]         cached_lane_reg, cached_lane_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [nlss_pkg::THR_W-1:0] thr_reg;
    logic [PW-1:0]         thr2_reg, thr2_next;
    nlss_pkg::lane_flags_t cflags_reg, cflags_next;
    logic [CB-1:0]         absx_reg, absx_next, absy_reg, absy_next;
    logic [PW-1:0]         sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [DW-1:0]         dist_reg, dist_next, best_reg, best_next;
    logic [AW-1:0]         best_i_reg, best_i_next;
    logic                  best_sweep_reg, best_sweep_next;
    logic                  found_reg, found_next;
    logic                  want_reg, want_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_sweep_reg, m_sweep_next;

    logic [AW-1:0]         rd_addr;
    logic                  idx_ok, back_ok, fwd_ok, elig, better, near_done, cache_hit;
    logic                  out_free;
    logic [CB-1:0]         ox, oy;
    logic [CB:0]           dx, dy, ndx, ndy;
    logic [MW-1:0]         mul_a;
    logic [PW-1:0]         prod;

    // Low COORD_BITS of a coordinate field, sign extended first.
    function automatic logic [CB-1:0] coord_of(
        input logic signed [nlss_pkg::FIELD_COORD_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[CB-1:0];
    endfunction

    // Decoded conditions used by the control blocks.
    assign idx_ok    = 32'(idx_reg) < LANE_ENTRIES;
    assign back_ok   = cflags_reg.back_valid && (32'(cflags_reg.back) < LANE_ENTRIES);
    assign fwd_ok    = cflags_reg.fwd_valid && (32'(cflags_reg.fwd) < LANE_ENTRIES);
    assign elig      = flags_q_reg.present && flags_q_reg.has_point;
    assign better    = !found_reg || (dist_reg < best_reg);
    assign near_done = found_reg && (best_reg < {1'b0, thr2_reg});
    assign cache_hit = dist_reg < {1'b0, thr2_reg};
    assign out_free  = !m_valid_reg || m_ready;

    // Memory read address.
    always_comb begin
        unique case (state_reg)
            nlss_pkg::ST_DECODE: rd_addr = AW'(idx_reg);
            nlss_pkg::ST_THR:    rd_addr = cached_lane_reg;
            default:             rd_addr = cand_reg;
        endcase
    end

    // Absolute coordinate differences against the cached pose or a lane.
    always_comb begin
        if (phase_reg == nlss_pkg::PH_CACHE) begin
            ox = cached_x_reg;
            oy = cached_y_reg;
        end else begin
            ox = pos_q_reg[2*CB-1:CB];
            oy = pos_q_reg[CB-1:0];
        end
        dx  = {pose_x_reg[CB-1], pose_x_reg} - {ox[CB-1], ox};
        dy  = {pose_y_reg[CB-1], pose_y_reg} - {oy[CB-1], oy};
        ndx = -dx;
        ndy = -dy;
    end

    // Shared squaring unit.
    always_comb begin
        unique case (state_reg)
            nlss_pkg::ST_THR: mul_a = MW'(thr_reg);
            nlss_pkg::ST_SQX: mul_a = MW'(absx_reg);
            default:          mul_a = MW'(absy_reg);
        endcase
        prod = mul_a * mul_a;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nlss_pkg::ST_CLEAR:
                if (cand_reg == LAST) state_next = nlss_pkg::ST_IDLE;
            nlss_pkg::ST_IDLE:
                if (s_valid) state_next = nlss_pkg::ST_DECODE;
            nlss_pkg::ST_DECODE: begin
                priority if (func_reg == nlss_pkg::FUNC_LANE_WRITE) begin
                    state_next = idx_ok ? nlss_pkg::ST_WRITE : nlss_pkg::ST_IDLE;
                end else if (func_reg == nlss_pkg::FUNC_SET_ENABLE) begin
                    state_next = en_val_reg ? nlss_pkg::ST_IDLE : nlss_pkg::ST_RESULT;
                end else if (func_reg == nlss_pkg::FUNC_POSE) begin
                    state_next = (enabled_reg && count_reg != '0) ? nlss_pkg::ST_THR
                                                                  : nlss_pkg::ST_IDLE;
                end else begin
                    state_next = nlss_pkg::ST_IDLE;
                end
            end
            nlss_pkg::ST_WRITE:
                state_next = nlss_pkg::ST_IDLE;
            nlss_pkg::ST_THR:
                state_next = cache_valid_reg ? nlss_pkg::ST_DIFF : nlss_pkg::ST_RD;
            nlss_pkg::ST_RD:
                state_next = nlss_pkg::ST_DIFF;
            nlss_pkg::ST_DIFF:
                if (phase_reg == nlss_pkg::PH_CACHE || elig) state_next = nlss_pkg::ST_SQX;
                else state_next = nlss_pkg::ST_NEXT;
            nlss_pkg::ST_SQX:
                state_next = nlss_pkg::ST_SQY;
            nlss_pkg::ST_SQY:
                state_next = nlss_pkg::ST_SUM;
            nlss_pkg::ST_SUM:
                state_next = nlss_pkg::ST_EVAL;
            nlss_pkg::ST_EVAL: begin
                if (phase_reg == nlss_pkg::PH_CACHE) begin
                    if (cache_hit)
                        state_next = cflags_reg.present ? nlss_pkg::ST_RESULT
                                                        : nlss_pkg::ST_IDLE;
                    else
                        state_next = nlss_pkg::ST_RD;
                end else begin
                    state_next = nlss_pkg::ST_NEXT;
                end
            end
            nlss_pkg::ST_NEXT: begin
                if (phase_reg == nlss_pkg::PH_NEAR) begin
                    unique case (step_reg)
                        nlss_pkg::NS_SELF: if (back_ok) state_next = nlss_pkg::ST_RD;
                        nlss_pkg::NS_BACK: if (fwd_ok) state_next = nlss_pkg::ST_RD;
                        default:
                            state_next = near_done ? nlss_pkg::ST_FINAL : nlss_pkg::ST_RD;
                    endcase
                end else begin
                    state_next = (cand_reg == LAST) ? nlss_pkg::ST_FINAL : nlss_pkg::ST_RD;
                end
            end
            nlss_pkg::ST_FINAL:
                state_next = nlss_pkg::ST_RESULT;
            nlss_pkg::ST_RESULT:
                if (want_reg == status_reg || out_free) state_next = nlss_pkg::ST_IDLE;
            default:
                state_next = nlss_pkg::ST_IDLE;
        endcase
    end

    // Datapath and status updates.
    always_comb begin
        phase_next       = phase_reg;
        step_next        = step_reg;
        cand_next        = cand_reg;
        enabled_next     = enabled_reg;
        status_next      = status_reg;
        cache_valid_next = cache_valid_reg;
        cached_x_next    = cached_x_reg;
        cached_y_next    = cached_y_reg;
        cached_lane_next = cached_lane_reg;
        count_next       = count_reg;
        thr2_next        = thr2_reg;
        cflags_next      = cflags_reg;
        absx_next        = absx_reg;
        absy_next        = absy_reg;
        sqx_next         = sqx_reg;
        sqy_next         = sqy_reg;
        dist_next        = dist_reg;
        best_next        = best_reg;
        best_i_next      = best_i_reg;
        best_sweep_next  = best_sweep_reg;
        found_next       = found_reg;
        want_next        = want_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_sweep_next     = m_sweep_reg;

        unique case (state_reg)
            nlss_pkg::ST_CLEAR:
                cand_next = cand_reg + AW'(1);
            nlss_pkg::ST_DECODE: begin
                if (func_reg == nlss_pkg::FUNC_SET_ENABLE) begin
                    enabled_next = en_val_reg;
                    if (en_val_reg) status_next = 1'b0;
                    else want_next = 1'b0;
                end
            end
            nlss_pkg::ST_WRITE: begin
                if (flags_q_reg.present && !new_flags_reg.present)
                    count_next = count_reg - CNT_W'(1);
                else if (!flags_q_reg.present && new_flags_reg.present)
                    count_next = count_reg + CNT_W'(1);
            end
            nlss_pkg::ST_THR: begin
                thr2_next  = prod;
                phase_next = cache_valid_reg ? nlss_pkg::PH_CACHE : nlss_pkg::PH_GLOBAL;
                cand_next  = '0;
                found_next = 1'b0;
            end
            nlss_pkg::ST_DIFF: begin
                if (phase_reg == nlss_pkg::PH_CACHE) cflags_next = flags_q_reg;
                absx_next = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
                absy_next = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
            end
            nlss_pkg::ST_SQX:
                sqx_next = prod;
            nlss_pkg::ST_SQY:
                sqy_next = prod;
            nlss_pkg::ST_SUM:
                dist_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
            nlss_pkg::ST_EVAL: begin
                if (phase_reg == nlss_pkg::PH_CACHE) begin
                    if (cache_hit) begin
                        want_next = cflags_reg.sweep;
                    end else begin
                        cand_next  = cached_lane_reg;
                        phase_next = nlss_pkg::PH_NEAR;
                        step_next  = nlss_pkg::NS_SELF;
                        found_next = 1'b0;
                    end
                end else if (better) begin
                    best_next       = dist_reg;
                    best_i_next     = cand_reg;
                    best_sweep_next = flags_q_reg.sweep;
                    found_next      = 1'b1;
                end
            end
            nlss_pkg::ST_NEXT: begin
                if (phase_reg == nlss_pkg::PH_NEAR) begin
                    unique case (step_reg)
                        nlss_pkg::NS_SELF: begin
                            step_next = nlss_pkg::NS_BACK;
                            if (back_ok) cand_next = AW'(cflags_reg.back);
                        end
                        nlss_pkg::NS_BACK: begin
                            step_next = nlss_pkg::NS_FWD;
                            if (fwd_ok) cand_next = AW'(cflags_reg.fwd);
                        end
                        default: begin
                            if (!near_done) begin
                                phase_next = nlss_pkg::PH_GLOBAL;
                                cand_next  = '0;
                            end
                        end
                    endcase
                end else if (cand_reg != LAST) begin
                    cand_next = cand_reg + AW'(1);
                end
            end
            nlss_pkg::ST_FINAL: begin
                if (found_reg) begin
                    cached_x_next    = pose_x_reg;
                    cached_y_next    = pose_y_reg;
                    cached_lane_next = best_i_reg;
                    cache_valid_next = 1'b1;
                    want_next        = best_sweep_reg;
                end else begin
                    cache_valid_next = 1'b0;
                    want_next        = 1'b0;
                end
            end
            nlss_pkg::ST_RESULT: begin
                if (want_reg != status_reg && out_free) begin
                    status_next  = want_reg;
                    m_valid_next = 1'b1;
                    m_sweep_next = want_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= nlss_pkg::ST_CLEAR;
            phase_reg       <= nlss_pkg::PH_CACHE;
            step_reg        <= nlss_pkg::NS_SELF;
            cand_reg        <= '0;
            enabled_reg     <= 1'b0;
            status_reg      <= 1'b0;
            cache_valid_reg <= 1'b0;
            cached_x_reg    <= '0;
            cached_y_reg    <= '0;
            cached_lane_reg <= '0;
            count_reg       <= '0;
            thr_reg         <= nlss_pkg::THR_RESET;
            found_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            step_reg        <= step_next;
            cand_reg        <= cand_next;
            enabled_reg     <= enabled_next;
            status_reg      <= status_next;
            cache_valid_reg <= cache_valid_next;
            cached_x_reg    <= cached_x_next;
            cached_y_reg    <= cached_y_next;
            cached_lane_reg <= cached_lane_next;
            count_reg       <= count_next;
            found_reg       <= found_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) thr_reg <= cfg_wr_data;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        thr2_reg       <= thr2_next;
        cflags_reg     <= cflags_next;
        absx_reg       <= absx_next;
        absy_reg       <= absy_next;
        sqx_reg        <= sqx_next;
        sqy_reg        <= sqy_next;
        dist_reg       <= dist_next;
        best_reg       <= best_next;
        best_i_reg     <= best_i_next;
        best_sweep_reg <= best_sweep_next;
        want_reg       <= want_next;
        m_sweep_reg    <= m_sweep_next;
        if (state_reg == nlss_pkg::ST_IDLE && s_valid) begin
            func_reg                 <= s_func;
            idx_reg                  <= s_lane_index;
            pose_x_reg               <= coord_of(s_pos_x);
            pose_y_reg               <= coord_of(s_pos_y);
            new_flags_reg.present    <= s_lane_present;
            new_flags_reg.has_point  <= s_lane_has_point;
            new_flags_reg.sweep      <= s_lane_sweep;
            new_flags_reg.back_valid <= s_back_link_valid;
            new_flags_reg.back       <= s_back_link;
            new_flags_reg.fwd_valid  <= s_fwd_link_valid;
            new_flags_reg.fwd        <= s_fwd_link;
            en_val_reg               <= s_enable_value;
        end
    end

    // Lane table memories: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (state_reg == nlss_pkg::ST_CLEAR) begin
            flags_mem[cand_reg] <= '0;
        end else if (state_reg == nlss_pkg::ST_WRITE) begin
            flags_mem[AW'(idx_reg)] <= new_flags_reg;
            pos_mem[AW'(idx_reg)]   <= {pose_x_reg, pose_y_reg};
        end
        flags_q_reg <= flags_mem[rd_addr];
        pos_q_reg   <= pos_mem[rd_addr];
    end

    assign s_ready    = (state_reg == nlss_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_sweep_on = m_sweep_reg;

    // A status change loads the output register with the new status.
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nlss_pkg::ST_RESULT && want_reg != status_reg && out_free)
        |=> (m_valid && m_sweep_on == $past(want_reg) && status_reg == $past(want_reg)))
        else $error("status change did not produce a result");

    // The present count never exceeds the table size.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= LANE_ENTRIES)
        else $error("present count out of range");

    // No transaction is taken during the clearing pass.
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nlss_pkg::ST_CLEAR) |-> !s_ready)
        else $error("transaction accepted during table clear");

    // The cache follows the outcome of a completed search.
    a_cache_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nlss_pkg::ST_FINAL) |=> (cache_valid_reg == $past(found_reg)))
        else $error("cache valid does not follow search outcome");

endmodule

// ===== sim/nearest_lane_sweep_selector_core_test.sv =====
// Self-checking testbench for the nearest lane sweep selector core.
module nearest_lane_sweep_selector_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LANES      = 256;
    localparam int unsigned SETTLE     = 6 * LANES + 200;
    localparam int unsigned STALL_MAX  = 20000;
    localparam int unsigned LONG_HOLD  = 600;

    // One input transaction, field by field.
    typedef struct {
        logic [1:0]         func;
        logic [7:0]         lane_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic               present;
        logic               has_point;
        logic               sweep;
        logic               back_valid;
        logic [7:0]         back;
        logic               fwd_valid;
        logic [7:0]         fwd;
        logic               enable_value;
    } lane_txn_t;

    // Predicts sweep status changes and checks the ones the block reports.
    class sweep_scoreboard;
        logic signed [23:0]         lane_x [LANES];
        logic signed [23:0]         lane_y [LANES];
        nlss_pkg::lane_flags_t      flags [LANES];
        int unsigned                present_count;
        logic signed [23:0]         last_x;
        logic signed [23:0]         last_y;
        int unsigned                last_lane;
        bit                         last_valid;
        bit                         enabled;
        bit                         status;
        logic [nlss_pkg::THR_W-1:0] threshold;
        bit                         expected_sweep [$];
        int unsigned                errors;
        longint unsigned            best_d;
        int unsigned                best_i;
        bit                         found;

        function new();
            for (int i = 0; i < LANES; i++) begin
                flags[i] = '0;
                lane_x[i] = '0;
                lane_y[i] = '0;
            end
            present_count = 0;
            last_x = '0;
            last_y = '0;
            last_lane = 0;
            last_valid = 0;
            enabled = 0;
            status = 0;
            threshold = nlss_pkg::THR_RESET;
            errors = 0;
        endfunction

        function longint unsigned sq_dist(logic signed [23:0] ax, logic signed [23:0] ay,
                                          logic signed [23:0] bx, logic signed [23:0] by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return longint'(dx * dx) + longint'(dy * dy);
        endfunction

        // Offers one lane as a candidate; ties keep the earlier one.
        function void consider(int unsigned idx, logic signed [23:0] px,
                               logic signed [23:0] py);
            longint unsigned d;
            if (idx >= LANES) return;
            if (!flags[idx].present || !flags[idx].has_point) return;
            d = sq_dist(px, py, lane_x[idx], lane_y[idx]);
            if (!found || d < best_d) begin
                best_d = d;
                best_i = idx;
                found = 1;
            end
        endfunction

        // Appends one expected status change.
        function void expect_sweep(bit v);
            expected_sweep = {expected_sweep, v};
        endfunction

        function void note_input(lane_txn_t t);
            longint unsigned thr2;
            bit want;
            bit done;
            nlss_pkg::lane_flags_t c;
            thr2 = longint'(threshold) * longint'(threshold);
            case (t.func)
                nlss_pkg::FUNC_LANE_WRITE: begin
                    if (flags[t.lane_index].present && !t.present) present_count--;
                    else if (!flags[t.lane_index].present && t.present) present_count++;
                    flags[t.lane_index] = '{t.present, t.has_point, t.sweep,
                                            t.back_valid, t.back, t.fwd_valid, t.fwd};
                    lane_x[t.lane_index] = t.pos_x;
                    lane_y[t.lane_index] = t.pos_y;
                    return;
                end
                nlss_pkg::FUNC_SET_ENABLE: begin
                    enabled = t.enable_value;
                    if (enabled) status = 0;
                    else if (status) begin
                        status = 0;
                        expect_sweep(1'b0);
                    end
                    return;
                end
                nlss_pkg::FUNC_POSE: ;
                default: return;
            endcase
            if (!enabled || present_count == 0) return;
            if (last_valid && sq_dist(t.pos_x, t.pos_y, last_x, last_y) < thr2) begin
                // Close to the last search pose: reuse the cached lane.
                if (!flags[last_lane].present) return;
                want = flags[last_lane].sweep;
            end else begin
                found = 0;
                best_d = 0;
                best_i = 0;
                done = 0;
                if (last_valid) begin
                    c = flags[last_lane];
                    consider(last_lane, t.pos_x, t.pos_y);
                    if (c.back_valid) consider(c.back, t.pos_x, t.pos_y);
                    if (c.fwd_valid) consider(c.fwd, t.pos_x, t.pos_y);
                    done = found && best_d < thr2;
                end
                if (!done)
                    for (int i = 0; i < LANES; i++) consider(i, t.pos_x, t.pos_y);
                if (found) begin
                    last_x = t.pos_x;
                    last_y = t.pos_y;
                    last_lane = best_i;
                    last_valid = 1;
                    want = flags[best_i].sweep;
                end else begin
                    last_valid = 0;
                    want = 0;
                end
            end
            if (want != status) begin
                status = want;
                expect_sweep(want);
            end
        endfunction

        function void check_result(bit actual);
            bit exp_val;
            if (expected_sweep.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual sweep_on=%0d",
                         $realtime, actual);
                errors++;
                return;
            end
            exp_val = expected_sweep.pop_front();
            if (exp_val !== actual) begin
                $display("%0t: sweep_on mismatch, expected %0d, actual %0d",
                         $realtime, exp_val, actual);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [nlss_pkg::THR_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic [7:0]         s_lane_index;
    logic signed [23:0] s_pos_x;
    logic signed [23:0] s_pos_y;
    logic               s_lane_present;
    logic               s_lane_has_point;
    logic               s_lane_sweep;
    logic               s_back_link_valid;
    logic [7:0]         s_back_link;
    logic               s_fwd_link_valid;
    logic [7:0]         s_fwd_link;
    logic               s_enable_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_sweep_on;

    sweep_scoreboard sb;
    bit              quiet;
    bit              hold_req;
    int unsigned     idle_cycles;
    logic signed [23:0] walk_x;
    logic signed [23:0] walk_y;

    nearest_lane_sweep_selector_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_lane_index      (s_lane_index),
        .s_pos_x           (s_pos_x),
        .s_pos_y           (s_pos_y),
        .s_lane_present    (s_lane_present),
        .s_lane_has_point  (s_lane_has_point),
        .s_lane_sweep      (s_lane_sweep),
        .s_back_link_valid (s_back_link_valid),
        .s_back_link       (s_back_link),
        .s_fwd_link_valid  (s_fwd_link_valid),
        .s_fwd_link        (s_fwd_link),
        .s_enable_value    (s_enable_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sweep_on        (m_sweep_on)
    );

    // Clock.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Result checker: compares every accepted result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_sweep_on);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("** nearest_lane_sweep_selector_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random ready bursts plus one long requested hold-off.
    initial begin : receiver
        int unsigned hold_cnt;
        int unsigned gap_cnt;
        hold_cnt = 0;
        gap_cnt = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (!quiet && gap_cnt > 0) begin
                gap_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) gap_cnt = $urandom_range(1, 14);
            end
        end
    end

    // Drives one input transaction and waits until it is accepted.
    task automatic send_txn(lane_txn_t t);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_func            <= t.func;
        s_lane_index      <= t.lane_index;
        s_pos_x           <= t.pos_x;
        s_pos_y           <= t.pos_y;
        s_lane_present    <= t.present;
        s_lane_has_point  <= t.has_point;
        s_lane_sweep      <= t.sweep;
        s_back_link_valid <= t.back_valid;
        s_back_link       <= t.back;
        s_fwd_link_valid  <= t.fwd_valid;
        s_fwd_link        <= t.fwd;
        s_enable_value    <= t.enable_value;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(t);
    endtask

    // Waits until the block is idle and then writes the threshold.
    task automatic write_threshold(logic [nlss_pkg::THR_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_sweep.size() != 0 || !s_ready) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.threshold = value;
    endtask

    function automatic lane_txn_t blank_txn(logic [1:0] func);
        lane_txn_t t;
        t = '{func: func, lane_index: '0, pos_x: '0, pos_y: '0, present: 0,
              has_point: 0, sweep: 0, back_valid: 0, back: '0, fwd_valid: 0,
              fwd: '0, enable_value: 0};
        return t;
    endfunction

    function automatic lane_txn_t lane_write(int unsigned idx, int px, int py, bit p,
                                             bit hp, bit sw, bit bv, int unsigned bk,
                                             bit fv, int unsigned fw);
        lane_txn_t t;
        t = blank_txn(nlss_pkg::FUNC_LANE_WRITE);
        t.lane_index = 8'(idx);
        t.pos_x = 24'(px);
        t.pos_y = 24'(py);
        t.present = p;
        t.has_point = hp;
        t.sweep = sw;
        t.back_valid = bv;
        t.back = 8'(bk);
        t.fwd_valid = fv;
        t.fwd = 8'(fw);
        return t;
    endfunction

    function automatic lane_txn_t pose(int px, int py);
        lane_txn_t t;
        t = blank_txn(nlss_pkg::FUNC_POSE);
        t.pos_x = 24'(px);
        t.pos_y = 24'(py);
        return t;
    endfunction

    function automatic lane_txn_t set_enable(bit v);
        lane_txn_t t;
        t = blank_txn(nlss_pkg::FUNC_SET_ENABLE);
        t.enable_value = v;
        return t;
    endfunction

    // Random transaction: mostly poses on a slow walk, lane writes near it.
    function automatic lane_txn_t random_txn();
        lane_txn_t t;
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(0, 99);
        t = blank_txn(nlss_pkg::FUNC_POSE);
        if (pick < 4) begin
            // Noise: every field random, including the unused function code.
            t.func = 2'($urandom_range(0, 3));
            t.lane_index = 8'($urandom);
            t.pos_x = 24'($urandom);
            t.pos_y = 24'($urandom);
            {t.present, t.has_point, t.sweep, t.back_valid, t.fwd_valid,
             t.enable_value} = 6'($urandom);
            t.back = 8'($urandom);
            t.fwd = 8'($urandom);
            if (t.func == nlss_pkg::FUNC_LANE_WRITE) t.has_point = t.present;
        end else if (pick < 36) begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 23);
            t = lane_write(idx,
                           int'(walk_x) + $signed($urandom_range(0, 1200)) - 600,
                           int'(walk_y) + $signed($urandom_range(0, 1200)) - 600,
                           $urandom_range(0, 7) != 0, 1'b1, $urandom_range(0, 1) != 0,
                           $urandom_range(0, 3) != 0,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : idx - 1,
                           $urandom_range(0, 3) != 0,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : idx + 1);
            if ($urandom_range(0, 9) == 0) t.has_point = 0;
        end else if (pick < 40) begin
            t = set_enable($urandom_range(0, 5) != 0);
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                walk_x = 24'($signed($urandom_range(0, 8000)) - 4000);
                walk_y = 24'($signed($urandom_range(0, 8000)) - 4000);
            end else begin
                walk_x = 24'(int'(walk_x) + $signed($urandom_range(0, 160)) - 80);
                walk_y = 24'(int'(walk_y) + $signed($urandom_range(0, 160)) - 80);
            end
            t = pose(int'(walk_x), int'(walk_y));
        end
        return t;
    endfunction

    task automatic random_phase(int unsigned count);
        repeat (count) send_txn(random_txn());
    endtask

    // Main sequence.
    initial begin
        sb = new();
        quiet = 0;
        hold_req = 0;
        walk_x = '0;
        walk_y = '0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_func = nlss_pkg::FUNC_LANE_WRITE;
        s_lane_index = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_lane_present = 1'b0;
        s_lane_has_point = 1'b0;
        s_lane_sweep = 1'b0;
        s_back_link_valid = 1'b0;
        s_back_link = '0;
        s_fwd_link_valid = 1'b0;
        s_fwd_link = '0;
        s_enable_value = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset threshold.
        send_txn(pose(0, 0));
        send_txn(set_enable(1'b1));
        send_txn(pose(0, 0));
        send_txn(lane_write(255, 8388607, -8388608, 1, 1, 1, 1, 0, 1, 254));
        send_txn(lane_write(0, -8388608, 8388607, 1, 1, 0, 1, 255, 1, 1));
        send_txn(lane_write(1, 0, 0, 1, 0, 1, 0, 0, 0, 0));
        send_txn(pose(8388607, -8388608));
        send_txn(pose(8388600, -8388600));
        send_txn(pose(-8388608, 8388607));
        send_txn(lane_write(2, 300, 0, 1, 1, 1, 1, 0, 1, 3));
        send_txn(lane_write(3, 600, 0, 1, 1, 0, 1, 2, 0, 0));
        send_txn(pose(310, 5));
        send_txn(pose(320, 10));
        send_txn(lane_write(2, 300, 0, 0, 1, 1, 1, 0, 1, 3));
        send_txn(pose(330, 10));
        send_txn(pose(590, 0));
        send_txn(blank_txn(2'd3));
        send_txn(lane_write(3, 600, 0, 1, 1, 1, 1, 2, 1, 0));
        send_txn(pose(5000, 5000));
        send_txn(set_enable(1'b0));
        send_txn(pose(600, 0));
        send_txn(set_enable(1'b1));
        send_txn(pose(600, 0));
        for (int i = 0; i < 4; i++)
            send_txn(lane_write(i == 3 ? 255 : i, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_txn(pose(0, 0));

        random_phase(350);
        write_threshold('0);
        random_phase(150);
        hold_req = 1;
        random_phase(200);
        write_threshold(23'h7FFFFF);
        random_phase(200);
        write_threshold(23'($urandom_range(1, 2000)));
        random_phase(250);
        write_threshold(nlss_pkg::THR_RESET);
        quiet = 1;
        random_phase(250);
        s_valid <= 1'b0;

        // Drain and finish.
        while (sb.expected_sweep.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_sweep.size() == 0) begin
            $display("** nearest_lane_sweep_selector_core: PASSED **");
        end else begin
            $display("** nearest_lane_sweep_selector_core: FAILED **");
        end
        $finish;
    end

endmodule
